@@ hw/rtl/neighbor_table_oldest_evict_assert.svh @@
// Assertion macros shared by the neighbor table RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef NEIGHBOR_TABLE_OLDEST_EVICT_ASSERT_SVH
`define NEIGHBOR_TABLE_OLDEST_EVICT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define NTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nte_pkg.sv @@
// Shared types, constants and helper functions of the neighbor table.
// No dependencies.
`timescale 1ns / 1ps

package nte_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BYTES     = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_SEEN  = 2'd0,
        OP_COUNT = 2'd1,
        OP_SNAP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic seen_write;
        logic count_emit;
        logic sort_load;
        logic sort_step;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_last;
        logic sort_done;
        logic sort_move;
        logic emit_done;
    } t_stat;

    function automatic logic [63:0] norm_key(input logic [63:0] k);
        logic [63:0] r;
        logic        run;
        r   = '0;
        run = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= KEY_BYTES || k[8*b +: 8] == 8'd0) begin
                run = 1'b0;
            end
            if (run) begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic is_older(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'd31) ? 5'd31 : w[4:0];
    endfunction

endpackage

@@ hw/rtl/nte_ctrl.sv @@
// Sequencing state machine of the neighbor table.
// Depends on nte_pkg; drives the datapath through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module nte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nte_pkg::t_stat i_stat,
    output nte_pkg::t_cmd  o_cmd
);
    import nte_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_COUNT = 7'b0001000,
        S_SLOAD = 7'b0010000,
        S_SSTEP = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.op == OP_NONE) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) begin
                        unique case (i_stat.op)
                            OP_SEEN:  n_state = S_WRITE;
                            OP_COUNT: n_state = S_COUNT;
                            OP_SNAP:  n_state = S_SLOAD;
                            default:  n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_WRITE: begin
                o_cmd.seen_write = 1'b1;
                n_state          = S_IDLE;
            end
            S_COUNT: begin
                o_cmd.count_emit = 1'b1;
                n_state          = S_IDLE;
            end
            S_SLOAD: begin
                if (i_stat.sort_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sort_load = 1'b1;
                    n_state         = S_SSTEP;
                end
            end
            S_SSTEP: begin
                o_cmd.sort_step = 1'b1;
                if (!i_stat.sort_move) begin
                    n_state = S_SLOAD;
                end
            end
            S_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_stat.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/nte_dp.sv @@
// Slot storage, scan logic, sort list and result registers of the neighbor table.
// Depends on nte_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "neighbor_table_oldest_evict_assert.svh"

module nte_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nte_pkg::t_cmd       i_cmd,
    output nte_pkg::t_stat      o_stat,
    input  logic [1:0]          i_operation,
    input  logic [31:0]         i_now_ms,
    input  logic [63:0]         i_name_key,
    input  logic [63:0]         i_version_key,
    input  logic [3:0]          i_node_kind,
    input  logic signed [11:0]  i_rssi_in,
    input  logic signed [7:0]   i_snr_in,
    input  logic [31:0]         i_max_age_ms,
    input  logic [4:0]          i_max_entries,
    output logic                o_valid,
    output logic                o_is_new,
    output logic [4:0]          o_count_value,
    output logic                o_entry_valid,
    output logic [63:0]         o_entry_name,
    output logic [63:0]         o_entry_version,
    output logic [3:0]          o_entry_kind,
    output logic signed [11:0]  o_entry_rssi,
    output logic signed [7:0]   o_entry_snr,
    output logic [31:0]         o_entry_time,
    output logic [31:0]         o_entry_beacons,
    output logic                o_last
);
    import nte_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_used;
    logic [63:0]              r_slot_name    [TABLE_ENTRIES];
    logic [63:0]              r_slot_version [TABLE_ENTRIES];
    logic [3:0]               r_slot_kind    [TABLE_ENTRIES];
    logic [11:0]              r_slot_rssi    [TABLE_ENTRIES];
    logic [7:0]               r_slot_snr     [TABLE_ENTRIES];
    logic [31:0]              r_slot_time    [TABLE_ENTRIES];
    logic [31:0]              r_slot_beacons [TABLE_ENTRIES];

    t_op         r_op;
    logic [31:0] r_now;
    logic [63:0] r_key;
    logic [63:0] r_ver;
    logic [3:0]  r_kind;
    logic [11:0] r_rssi;
    logic [7:0]  r_snr;
    logic [31:0] r_lim;
    logic [4:0]  r_maxn;

    logic [IDX_W-1:0] r_idx;
    logic             r_match_hit, r_free_hit;
    logic [IDX_W-1:0] r_match_idx, r_free_idx, r_old_idx;
    logic [31:0]      r_old_time;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_k;
    logic [IDX_W-1:0] r_sel   [TABLE_ENTRIES];
    logic [31:0]      r_stime [TABLE_ENTRIES];
    logic [CNT_W-1:0] r_si, r_sj, r_r;
    logic [IDX_W-1:0] r_tidx;
    logic [31:0]      r_ttime;

    logic [IDX_W-1:0] rd_addr, wr_slot, emit_slot;
    logic [CNT_W-1:0] jm1, k_m1;
    logic             sort_move, emit_last, fresh;
    logic [31:0]      age;

    assign fresh     = !r_match_hit;
    assign wr_slot   = r_match_hit ? r_match_idx : (r_free_hit ? r_free_idx : r_old_idx);
    assign emit_slot = r_sel[r_r[IDX_W-1:0]];
    assign rd_addr   = i_cmd.seen_write ? wr_slot : (i_cmd.emit_step ? emit_slot : r_idx);
    assign jm1       = r_sj - CNT_W'(1);
    assign k_m1      = r_k - CNT_W'(1);
    assign sort_move = (r_sj != '0) && is_older(r_stime[jm1[IDX_W-1:0]], r_ttime);
    assign emit_last = (r_k == '0) || (r_r == k_m1);
    assign age       = r_now - r_slot_time[rd_addr];

    assign o_stat.op        = r_op;
    assign o_stat.scan_last = (32'(r_idx) == TABLE_ENTRIES - 1);
    assign o_stat.sort_done = (32'(r_si) >= 32'(r_k));
    assign o_stat.sort_move = sort_move;
    assign o_stat.emit_done = emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.seen_write) begin
            r_used[wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seen_write) begin
            r_slot_name[wr_slot]    <= r_key;
            r_slot_version[wr_slot] <= r_ver;
            r_slot_kind[wr_slot]    <= r_kind;
            r_slot_rssi[wr_slot]    <= r_rssi;
            r_slot_snr[wr_slot]     <= r_snr;
            r_slot_time[wr_slot]    <= r_now;
            r_slot_beacons[wr_slot] <= fresh ? 32'd1 : r_slot_beacons[wr_slot] + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_operation);
            r_now       <= i_now_ms;
            r_key       <= norm_key(i_name_key);
            r_ver       <= norm_key(i_version_key);
            r_kind      <= i_node_kind;
            r_rssi      <= i_rssi_in;
            r_snr       <= i_snr_in;
            r_lim       <= i_max_age_ms;
            r_maxn      <= i_max_entries;
            r_idx       <= '0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_si        <= CNT_W'(1);
            r_r         <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_used[rd_addr] && r_slot_name[rd_addr] == r_key && !r_match_hit) begin
                r_match_hit <= 1'b1;
                r_match_idx <= rd_addr;
            end
            if (!r_used[rd_addr] && !r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_idx <= rd_addr;
            end
            if (r_idx == '0 || is_older(r_slot_time[rd_addr], r_old_time)) begin
                r_old_idx  <= rd_addr;
                r_old_time <= r_slot_time[rd_addr];
            end
            if (r_op == OP_COUNT && r_used[rd_addr] && age <= r_lim) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_op == OP_SNAP && r_used[rd_addr] && 32'(r_k) < 32'(r_maxn)) begin
                r_sel[r_k[IDX_W-1:0]]   <= rd_addr;
                r_stime[r_k[IDX_W-1:0]] <= r_slot_time[rd_addr];
                r_k                     <= r_k + CNT_W'(1);
            end
        end
        if (i_cmd.sort_load) begin
            r_tidx  <= r_sel[r_si[IDX_W-1:0]];
            r_ttime <= r_stime[r_si[IDX_W-1:0]];
            r_sj    <= r_si;
        end
        if (i_cmd.sort_step) begin
            if (sort_move) begin
                r_sel[r_sj[IDX_W-1:0]]   <= r_sel[jm1[IDX_W-1:0]];
                r_stime[r_sj[IDX_W-1:0]] <= r_stime[jm1[IDX_W-1:0]];
                r_sj                     <= jm1;
            end else begin
                r_sel[r_sj[IDX_W-1:0]]   <= r_tidx;
                r_stime[r_sj[IDX_W-1:0]] <= r_ttime;
                r_si                     <= r_si + CNT_W'(1);
            end
        end
        if (i_cmd.emit_step) begin
            r_r <= r_r + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.seen_write || i_cmd.count_emit || i_cmd.emit_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_step && r_k != '0) begin
            o_is_new        <= 1'b0;
            o_count_value   <= sat_count(r_k);
            o_entry_valid   <= 1'b1;
            o_entry_name    <= r_slot_name[rd_addr];
            o_entry_version <= r_slot_version[rd_addr];
            o_entry_kind    <= r_slot_kind[rd_addr];
            o_entry_rssi    <= r_slot_rssi[rd_addr];
            o_entry_snr     <= r_slot_snr[rd_addr];
            o_entry_time    <= r_slot_time[rd_addr];
            o_entry_beacons <= r_slot_beacons[rd_addr];
            o_last          <= emit_last;
        end else if (i_cmd.seen_write || i_cmd.count_emit || i_cmd.emit_step) begin
            o_is_new        <= i_cmd.seen_write && fresh;
            o_count_value   <= i_cmd.count_emit ? sat_count(r_cnt) : 5'd0;
            o_entry_valid   <= 1'b0;
            o_entry_name    <= '0;
            o_entry_version <= '0;
            o_entry_kind    <= '0;
            o_entry_rssi    <= '0;
            o_entry_snr     <= '0;
            o_entry_time    <= '0;
            o_entry_beacons <= '0;
            o_last          <= 1'b1;
        end
    end

    `NTE_ASSERT_NEXT(a_snap_contiguous, o_valid && !o_last, o_valid, "snapshot transfer gap")
    `NTE_ASSERT_SAME(a_entry_count, o_valid && o_entry_valid, o_count_value != 5'd0, "entry with zero count")
    `NTE_ASSERT_SAME(a_sel_bound, i_cmd.scan_step, 32'(r_k) <= TABLE_ENTRIES, "selection overflow")
    `NTE_ASSERT_NEXT(a_write_result, i_cmd.seen_write, o_valid && o_last, "seen result missing")

endmodule

@@ hw/rtl/neighbor_table_oldest_evict.sv @@
// Top level of the neighbor table with oldest-entry eviction.
// Depends on nte_pkg, nte_ctrl and nte_dp.
//
// Usage: present an item on the i_* fields with start high; it is taken at
// a rising edge where busy is low. Operation seen updates or takes a slot and
// gives one result; count gives one result with the number of used entries
// whose age is at most i_max_age_ms; snapshot gives one result per selected
// entry, newest first, or one empty result when none is selected. Operation
// code 3 is dropped with no result. Each result transfer is marked by o_valid
// for one cycle, with o_last on the final one; the receiver cannot stall.
// Every item but code 3 scans all 16 slots, one per cycle. A snapshot of k
// entries, k at least one, then runs an insertion sort of the selected entries
// and emits them in order. busy stays high until the last result is issued,
// so one item is in work at a time.
// Reset clears all slot used flags at once; no clearing pass is needed.
`timescale 1ns / 1ps

module neighbor_table_oldest_evict (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_now_ms,
    input  logic [63:0]        i_name_key,
    input  logic [63:0]        i_version_key,
    input  logic [3:0]         i_node_kind,
    input  logic signed [11:0] i_rssi_in,
    input  logic signed [7:0]  i_snr_in,
    input  logic [31:0]        i_max_age_ms,
    input  logic [4:0]         i_max_entries,
    output logic               o_valid,
    output logic               o_is_new,
    output logic [4:0]         o_count_value,
    output logic               o_entry_valid,
    output logic [63:0]        o_entry_name,
    output logic [63:0]        o_entry_version,
    output logic [3:0]         o_entry_kind,
    output logic signed [11:0] o_entry_rssi,
    output logic signed [7:0]  o_entry_snr,
    output logic [31:0]        o_entry_time,
    output logic [31:0]        o_entry_beacons,
    output logic               o_last
);
    import nte_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    nte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    nte_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_now_ms        (i_now_ms),
        .i_name_key      (i_name_key),
        .i_version_key   (i_version_key),
        .i_node_kind     (i_node_kind),
        .i_rssi_in       (i_rssi_in),
        .i_snr_in        (i_snr_in),
        .i_max_age_ms    (i_max_age_ms),
        .i_max_entries   (i_max_entries),
        .o_valid         (o_valid),
        .o_is_new        (o_is_new),
        .o_count_value   (o_count_value),
        .o_entry_valid   (o_entry_valid),
        .o_entry_name    (o_entry_name),
        .o_entry_version (o_entry_version),
        .o_entry_kind    (o_entry_kind),
        .o_entry_rssi    (o_entry_rssi),
        .o_entry_snr     (o_entry_snr),
        .o_entry_time    (o_entry_time),
        .o_entry_beacons (o_entry_beacons),
        .o_last          (o_last)
    );

endmodule

@@ test/tb_neighbor_table_oldest_evict.sv @@
// Self-checking testbench for neighbor_table_oldest_evict: a directed table, then random traffic.
// Every result is checked against an in-bench model of the slot table or a typed directed row.
// Depends on nte_pkg and the neighbor_table_oldest_evict RTL.
`timescale 1ns / 1ps

module tb_neighbor_table_oldest_evict;
    import nte_pkg::*;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 500;

    typedef struct {
        t_op         op;
        logic [31:0] now;
        logic [63:0] name;
        logic [63:0] version;
        logic [3:0]  kind;
        logic [11:0] rssi;
        logic [7:0]  snr;
        logic [31:0] age;
        logic [4:0]  maxn;
    } t_item;

    typedef struct {
        logic        is_new;
        logic [4:0]  count;
        logic        ent_valid;
        logic [63:0] name;
        logic [63:0] version;
        logic [3:0]  kind;
        logic [11:0] rssi;
        logic [7:0]  snr;
        logic [31:0] tstamp;
        logic [31:0] beacons;
        logic        last;
    } t_res;

    typedef struct {
        t_item item;
        bit    typed;
        logic  is_new;
        logic [4:0] count;
        logic  ent_valid;
    } t_row;

    logic i_clk, i_rst_n, start, busy;
    logic [1:0] i_operation;
    logic [31:0] i_now_ms, i_max_age_ms;
    logic [63:0] i_name_key, i_version_key;
    logic [3:0] i_node_kind;
    logic signed [11:0] i_rssi_in;
    logic signed [7:0] i_snr_in;
    logic [4:0] i_max_entries;
    logic o_valid, o_is_new, o_entry_valid, o_last;
    logic [4:0] o_count_value;
    logic [63:0] o_entry_name, o_entry_version;
    logic [3:0] o_entry_kind;
    logic signed [11:0] o_entry_rssi;
    logic signed [7:0] o_entry_snr;
    logic [31:0] o_entry_time, o_entry_beacons;

    neighbor_table_oldest_evict i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_now_ms(i_now_ms), .i_name_key(i_name_key),
        .i_version_key(i_version_key), .i_node_kind(i_node_kind), .i_rssi_in(i_rssi_in),
        .i_snr_in(i_snr_in), .i_max_age_ms(i_max_age_ms), .i_max_entries(i_max_entries),
        .o_valid(o_valid), .o_is_new(o_is_new), .o_count_value(o_count_value),
        .o_entry_valid(o_entry_valid), .o_entry_name(o_entry_name),
        .o_entry_version(o_entry_version), .o_entry_kind(o_entry_kind),
        .o_entry_rssi(o_entry_rssi), .o_entry_snr(o_entry_snr),
        .o_entry_time(o_entry_time), .o_entry_beacons(o_entry_beacons), .o_last(o_last)
    );

    // Model of the slot table.
    bit          tab_used[SLOTS];
    logic [63:0] tab_name[SLOTS];
    logic [63:0] tab_version[SLOTS];
    logic [3:0]  tab_kind[SLOTS];
    logic [11:0] tab_rssi[SLOTS];
    logic [7:0]  tab_snr[SLOTS];
    logic [31:0] tab_time[SLOTS];
    logic [31:0] tab_beacons[SLOTS];

    t_res   pending_results[$];
    t_row   directed_rows[$];
    int     errors = 0;
    int     results_seen = 0;
    int     n_seen = 0, n_count = 0, n_snap = 0, n_evict = 0;
    int     cycles = 0;
    logic [31:0] clock_ms = 32'd1000;
    logic [63:0] name_pool[24];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("neighbor_table_oldest_evict regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] trim_key(input logic [63:0] k);
        logic [63:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            if (k[8*b +: 8] == 8'd0) break;
            r[8*b +: 8] = k[8*b +: 8];
        end
        return r;
    endfunction

    function automatic bit earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic t_res blank_result();
        t_res r;
        r = '{default: '0};
        return r;
    endfunction

    task automatic predict_table(input t_item it);
        t_res r;
        logic [63:0] key;
        int s, k, j, t;
        int sel[SLOTS];
        int c;
        r = blank_result();
        r.last = 1'b1;
        case (it.op)
            OP_SEEN: begin
                n_seen++;
                key = trim_key(it.name);
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && tab_used[i] && tab_name[i] == key) s = i;
                if (s < 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && !tab_used[i]) s = i;
                    if (s < 0) begin
                        n_evict++;
                        s = 0;
                        for (int i = 0; i < SLOTS; i++)
                            if (earlier(tab_time[i], tab_time[s])) s = i;
                    end
                    tab_used[s] = 1'b1;
                    tab_name[s] = key;
                    tab_beacons[s] = '0;
                    r.is_new = 1'b1;
                end
                tab_version[s] = trim_key(it.version);
                tab_kind[s] = it.kind;
                tab_rssi[s] = it.rssi;
                tab_snr[s] = it.snr;
                tab_time[s] = it.now;
                tab_beacons[s] = tab_beacons[s] + 32'd1;
                pending_results.push_back(r);
            end
            OP_COUNT: begin
                n_count++;
                c = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tab_used[i] && (it.now - tab_time[i]) <= it.age) c++;
                r.count = (c > 31) ? 5'd31 : 5'(c);
                pending_results.push_back(r);
            end
            OP_SNAP: begin
                n_snap++;
                k = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tab_used[i] && k < it.maxn) begin
                        sel[k] = i;
                        k++;
                    end
                for (int i = 1; i < k; i++) begin
                    t = sel[i];
                    j = i;
                    while (j > 0 && earlier(tab_time[sel[j-1]], tab_time[t])) begin
                        sel[j] = sel[j-1];
                        j--;
                    end
                    sel[j] = t;
                end
                if (k == 0) pending_results.push_back(r);
                for (int i = 0; i < k; i++) begin
                    s = sel[i];
                    r.count = 5'(k);
                    r.ent_valid = 1'b1;
                    r.name = tab_name[s];
                    r.version = tab_version[s];
                    r.kind = tab_kind[s];
                    r.rssi = tab_rssi[s];
                    r.snr = tab_snr[s];
                    r.tstamp = tab_time[s];
                    r.beacons = tab_beacons[s];
                    r.last = (i == k - 1);
                    pending_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transfer, actual count %0d last %b",
                         $time, o_count_value, o_last);
            end else begin
                e = pending_results.pop_front();
                check_field("is_new", e.is_new, o_is_new);
                check_field("count_value", e.count, o_count_value);
                check_field("entry_valid", e.ent_valid, o_entry_valid);
                check_field("entry_name", e.name, o_entry_name);
                check_field("entry_version", e.version, o_entry_version);
                check_field("entry_kind", e.kind, o_entry_kind);
                check_field("entry_rssi", e.rssi, $unsigned(o_entry_rssi));
                check_field("entry_snr", e.snr, $unsigned(o_entry_snr));
                check_field("entry_time", e.tstamp, o_entry_time);
                check_field("entry_beacons", e.beacons, o_entry_beacons);
                check_field("last", e.last, o_last);
            end
        end
    end

    // Drives one item and returns after its transfer; start stays high for the next one.
    task automatic send_item(input t_item it, output bit accepted_ok);
        @(negedge i_clk);
        start <= 1'b1;
        i_operation <= it.op;
        i_now_ms <= it.now;
        i_name_key <= it.name;
        i_version_key <= it.version;
        i_node_kind <= it.kind;
        i_rssi_in <= it.rssi;
        i_snr_in <= it.snr;
        i_max_age_ms <= it.age;
        i_max_entries <= it.maxn;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        accepted_ok = 1'b1;
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_item make_item(input t_op op, input logic [31:0] now,
                                        input logic [63:0] name, input logic [63:0] version,
                                        input logic [3:0] kind, input logic [11:0] rssi,
                                        input logic [7:0] snr, input logic [31:0] age,
                                        input logic [4:0] maxn);
        t_item it;
        it.op = op; it.now = now; it.name = name; it.version = version; it.kind = kind;
        it.rssi = rssi; it.snr = snr; it.age = age; it.maxn = maxn;
        return it;
    endfunction

    task automatic add_row(input t_item it, input bit typed, input logic is_new,
                           input logic [4:0] count, input logic ent_valid);
        t_row r;
        r.item = it; r.typed = typed; r.is_new = is_new; r.count = count;
        r.ent_valid = ent_valid;
        directed_rows.push_back(r);
    endtask

    function automatic t_item random_item();
        t_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.op = (pick < 60) ? OP_SEEN : (pick < 78) ? OP_COUNT : (pick < 97) ? OP_SNAP : OP_NONE;
        if ($urandom_range(0, 49) == 0) clock_ms = {$urandom};
        else clock_ms = clock_ms + $urandom_range(0, 400);
        it.now = clock_ms;
        if ($urandom_range(0, 9) == 0) it.name = {$urandom, $urandom};
        else it.name = name_pool[$urandom_range(0, 23)];
        // A trailing garbage byte after a zero byte must not change the match.
        if ($urandom_range(0, 7) == 0 && it.name[63:56] == 8'd0)
            it.name[63:56] = 8'($urandom_range(1, 255));
        it.version = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) it.version[8*$urandom_range(0, 7) +: 8] = 8'd0;
        if ($urandom_range(0, 9) == 0) it.version = '0;
        it.kind = 4'($urandom);
        it.rssi = 12'($urandom);
        it.snr = 8'($urandom);
        case ($urandom_range(0, 4))
            0: it.age = 32'd0;
            1: it.age = 32'hFFFF_FFFF;
            2: it.age = {$urandom};
            default: it.age = $urandom_range(0, 3000);
        endcase
        it.maxn = 5'($urandom_range(0, 16));
        return it;
    endfunction

    initial begin
        t_item it;
        t_row row;
        bit ok;
        int before_count;
        start = 1'b0;
        i_operation = OP_NONE;
        i_now_ms = '0; i_name_key = '0; i_version_key = '0; i_node_kind = '0;
        i_rssi_in = '0; i_snr_in = '0; i_max_age_ms = '0; i_max_entries = '0;
        for (int i = 0; i < SLOTS; i++) tab_used[i] = 1'b0;
        for (int i = 0; i < 24; i++) begin
            name_pool[i] = {$urandom, $urandom} | 64'h0101_0101_0101_0101;
            if (i % 3 == 0)
                name_pool[i] = name_pool[i] & ((64'd1 << (8 * $urandom_range(1, 7))) - 64'd1);
        end
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(make_item(OP_COUNT, 32'd100, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0), 1, 0, 0, 0);
        add_row(make_item(OP_SNAP, 32'd100, 0, 0, 0, 0, 0, 0, 5'd16), 1, 0, 0, 0);
        add_row(make_item(OP_SEEN, 32'd100, 64'h41, 64'h31, 4'hF, 12'h800, 8'h80, 0, 0),
                1, 1, 0, 0);
        add_row(make_item(OP_SEEN, 32'd150, 64'h41, 0, 4'h0, 12'h7FF, 8'h7F, 0, 0),
                1, 0, 0, 0);
        add_row(make_item(OP_SEEN, 32'd160, 64'hFF00_0000_0000_0041, 64'hAB00_3200, 4'h3,
                          12'h001, 8'h01, 0, 0), 1, 0, 0, 0);
        add_row(make_item(OP_SEEN, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 4'hA, 12'hFFF, 8'hFF, 0, 0), 1, 1, 0, 0);
        add_row(make_item(OP_SEEN, 32'd0, 64'h0, 64'h0, 4'h5, 12'h000, 8'h00, 0, 0),
                1, 1, 0, 0);
        add_row(make_item(OP_SEEN, 32'd0, 64'hFFFF_FFFF_FFFF_FF00, 64'h7, 4'h6, 12'h100,
                          8'h10, 0, 0), 1, 0, 0, 0);
        add_row(make_item(OP_SEEN, 32'd160, 64'h42, 64'h55, 4'h1, 12'h010, 8'h02, 0, 0),
                1, 1, 0, 0);
        add_row(make_item(OP_NONE, 32'd170, 64'h99, 64'h1, 4'h2, 12'h020, 8'h03, 0, 0),
                0, 0, 0, 0);
        add_row(make_item(OP_COUNT, 32'd160, 0, 0, 0, 0, 0, 32'd0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_COUNT, 32'd200, 0, 0, 0, 0, 0, 32'd100, 0), 0, 0, 0, 0);
        add_row(make_item(OP_COUNT, 32'd200, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0), 1, 0, 4, 0);
        add_row(make_item(OP_SNAP, 32'd200, 0, 0, 0, 0, 0, 0, 5'd0), 1, 0, 0, 0);
        add_row(make_item(OP_SNAP, 32'd200, 0, 0, 0, 0, 0, 0, 5'd1), 0, 0, 0, 0);
        add_row(make_item(OP_SNAP, 32'd200, 0, 0, 0, 0, 0, 0, 5'd2), 0, 0, 0, 0);
        add_row(make_item(OP_SNAP, 32'd200, 0, 0, 0, 0, 0, 0, 5'd16), 0, 0, 0, 0);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_item(row.item, ok);
            before_count = pending_results.size();
            predict_table(row.item);
            if (row.typed) begin
                pending_results[before_count].is_new = row.is_new;
                pending_results[before_count].count = row.count;
                pending_results[before_count].ent_valid = row.ent_valid;
            end
        end

        // Drain fully before random traffic starts.
        pause_sender(0);
        while (pending_results.size() != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it = random_item();
            send_item(it, ok);
            predict_table(it);
            if ((n < 150 || n >= 300) && $urandom_range(0, 99) < 10)
                pause_sender($urandom_range(1, 40));
            if (n == 350) begin
                pause_sender(0);
                while (pending_results.size() != 0) @(negedge i_clk);
            end
        end

        pause_sender(0);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("Covered %0d seen (%0d evictions), %0d count and %0d snapshot items;",
                 n_seen, n_evict, n_count, n_snap);
        $display("%0d result transfers were checked, with %0d mismatches.", results_seen, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("neighbor_table_oldest_evict regression: pass");
        end else begin
            $display("neighbor_table_oldest_evict regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/nte_pkg.sv
hw/rtl/nte_ctrl.sv
hw/rtl/nte_dp.sv
hw/rtl/neighbor_table_oldest_evict.sv
test/tb_neighbor_table_oldest_evict.sv
